// ----- sv/dtf_pkg.sv -----
package dtf_pkg;

  localparam int MAG_W      = 32;
  localparam int FRAC_W     = 4;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_IW     = $clog2(NUM_DIGITS);
  localparam int DD_STAGES  = 4;
  localparam int DD_STEPS   = MAG_W / DD_STAGES;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // one number on its way through the binary to bcd stages
  typedef struct packed {
    logic                       op;
    logic                       neg;
    logic [FRAC_W-1:0]          frac;
    logic [MAG_W-1:0]           bin;
    logic [NUM_DIGITS-1:0][3:0] bcd;
  } dtf_item_t;

endpackage

// ----- sv/dtf_dabble.sv -----
module dtf_dabble #(
  parameter int STEPS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  dtf_pkg::dtf_item_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dtf_pkg::dtf_item_t data_o
);
  import dtf_pkg::*;

  logic      valid_q;
  dtf_item_t data_q, data_d;

  // shift-add-3 over STEPS input bits
  always_comb begin
    data_d = data_i;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (data_d.bcd[d] >= 4'd5) begin
          data_d.bcd[d] = data_d.bcd[d] + 4'd3;
        end
      end
      {data_d.bcd, data_d.bin} = {data_d.bcd, data_d.bin} << 1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/dtf_serial.sv -----
module dtf_serial #(
  parameter int MAX_CHARS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  dtf_pkg::dtf_item_t         data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [dtf_pkg::CHAR_W-1:0] char_o,
  output logic                       last_o
);
  import dtf_pkg::*;

  localparam int PW   = $clog2(MAX_CHARS);
  localparam int PMAX = MAX_CHARS - 3;

  logic                       busy_q;
  logic                       op_q;
  logic                       neg_q;
  logic [NUM_DIGITS-1:0][3:0] bcd_q;
  logic [PW-1:0]              p_q, p_d;
  logic [PW-1:0]              len_q, len_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic [DIG_IW:0]            nsig;
  logic [PW-1:0]              frac_ext;
  logic [PW-1:0]              dig_idx;
  logic [3:0]                 digit;

  // length of the text without the sign, counted at load
  always_comb begin
    nsig = (DIG_IW + 1)'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (data_i.bcd[i] != 4'd0) begin
        nsig = (DIG_IW + 1)'(i + 1);
      end
    end
    frac_ext = PW'(data_i.frac);
    p_d      = (frac_ext > PW'(PMAX)) ? PW'(PMAX) : frac_ext;
    if (data_i.op) begin
      len_d = ((PW'(nsig) > p_d) ? PW'(nsig) : p_d + PW'(1)) + PW'(1);
    end else begin
      len_d = PW'(nsig);
    end
    pos_d = data_i.neg ? len_d : len_d - PW'(1);
  end

  assign ready_o = !busy_q || (ready_i && pos_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (ready_o) begin
      busy_q <= valid_i;
      if (valid_i) begin
        pos_q <= pos_d;
      end
    end else if (ready_i) begin
      pos_q <= pos_q - PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      op_q  <= data_i.op;
      neg_q <= data_i.neg;
      bcd_q <= data_i.bcd;
      p_q   <= p_d;
      len_q <= len_d;
    end
  end

  // pos counts down from the first character to zero on the last one
  always_comb begin
    dig_idx = (op_q && pos_q > p_q) ? pos_q - PW'(1) : pos_q;
    digit   = (dig_idx < PW'(NUM_DIGITS)) ? bcd_q[dig_idx[DIG_IW-1:0]] : 4'd0;
    if (neg_q && pos_q == len_q) begin
      char_o = CH_MINUS;
    end else if (op_q && pos_q == p_q) begin
      char_o = CH_POINT;
    end else begin
      char_o = CH_ZERO + CHAR_W'(digit);
    end
  end

  assign valid_o = busy_q;
  assign last_o  = (pos_q == '0);

endmodule

// ----- sv/decimal_text_formatter_top.sv -----
// channel   direction  contents
// s_axis    in         tuser: op; tdata: negative, magnitude
// m_axis    out        tdata: text_char; tlast: last
// cfg       in         cfg_wdata_i: fraction_digits
//
// four binary to bcd stages of eight bits each, one number entering per
// cycle while they are not stalled; the character stage sends one character
// a cycle while the output is ready, a number has 1 to MAX_CHARS characters,
// and that stage sets the sustained rate
// reset is asynchronous, active low; fraction_digits resets to 3
// a stalled output holds its character and back-pressure reaches the input
module decimal_text_formatter_top #(
  parameter int MAX_CHARS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // negative, magnitude, zero pad
  input  logic                       s_axis_tuser,  // op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [dtf_pkg::CHAR_W-1:0] m_axis_tdata,  // text_char
  output logic                       m_axis_tlast,
  input  logic                       cfg_we_i,
  input  logic [dtf_pkg::FRAC_W-1:0] cfg_wdata_i
);
  import dtf_pkg::*;

  logic [FRAC_W-1:0] fraction_digits_q;

  logic      st_valid [DD_STAGES+1];
  logic      st_ready [DD_STAGES+1];
  dtf_item_t st_data  [DD_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fraction_digits_q <= FRAC_RESET;
    end else if (cfg_we_i) begin
      fraction_digits_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    st_data[0]      = '0;
    st_data[0].op   = s_axis_tuser;
    st_data[0].neg  = s_axis_tdata[0];
    st_data[0].bin  = s_axis_tdata[MAG_W:1];
    st_data[0].frac = fraction_digits_q;
  end

  assign st_valid[0]   = s_axis_tvalid;
  assign s_axis_tready = st_ready[0];

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dabble
    dtf_dabble #(
      .STEPS (DD_STEPS)
    ) u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .ready_o (st_ready[g]),
      .data_i  (st_data[g]),
      .valid_o (st_valid[g+1]),
      .ready_i (st_ready[g+1]),
      .data_o  (st_data[g+1])
    );
  end

  dtf_serial #(
    .MAX_CHARS (MAX_CHARS)
  ) u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid[DD_STAGES]),
    .ready_o (st_ready[DD_STAGES]),
    .data_i  (st_data[DD_STAGES]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .char_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >= CH_ZERO && m_axis_tdata <= CH_NINE) ||
                      m_axis_tdata == CH_POINT || m_axis_tdata == CH_MINUS)
    else $error("character outside digits, point and minus");

  a_last_not_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata != CH_MINUS)
    else $error("number ends in a minus");

  a_mid_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata != CH_MINUS)
    else $error("number broken off or minus inside it");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import dtf_pkg::*;

  localparam int MAX_CHARS  = 12;
  localparam int FRAC_CAP   = MAX_CHARS - 3;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_WAIT = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata;  // negative, magnitude, zero pad
  logic              s_axis_tuser;  // op
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [CHAR_W-1:0] m_axis_tdata;  // text_char
  logic              m_axis_tlast;
  logic              cfg_we_i;
  logic [FRAC_W-1:0] cfg_wdata_i;

  decimal_text_formatter_top #(
    .MAX_CHARS(MAX_CHARS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  class decimal_text_checker;
    text_char_t        expected_chars[$];
    logic [FRAC_W-1:0] fraction;
    int                errors;

    function new();
      fraction = FRAC_RESET;
      errors   = 0;
    endfunction

    // builds the text of one number from the right-hand end
    function void note_number(logic fixed_fmt, logic neg, logic [MAG_W-1:0] mag);
      logic [CHAR_W-1:0] txt[$];
      logic [MAG_W-1:0]  rest;
      int                prec;
      int                len;
      text_char_t        item;
      rest = mag;
      prec = (fraction > FRAC_CAP) ? FRAC_CAP : int'(fraction);
      len  = 0;
      if (!fixed_fmt) begin
        do begin
          txt.push_front(CH_ZERO + CHAR_W'(rest % 32'd10));
          rest = rest / 32'd10;
        end while (rest != 0 && txt.size() < MAX_CHARS);
      end else begin
        do begin
          len++;
          if (len == prec + 1) begin
            txt.push_front(CH_POINT);
          end else begin
            txt.push_front(CH_ZERO + CHAR_W'(rest % 32'd10));
            rest = rest / 32'd10;
          end
        end while ((rest != 0 || len < prec + 2) && txt.size() < MAX_CHARS);
      end
      if (neg && txt.size() < MAX_CHARS) txt.push_front(CH_MINUS);
      foreach (txt[k]) begin
        item.code    = txt[k];
        item.is_last = (k == txt.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic is_last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: char %h last %b", code, is_last);
        return;
      end
      want = expected_chars.pop_front();
      if (want.code !== code || want.is_last !== is_last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: char exp %h got %h, last exp %b got %b",
                   want.code, code, want.is_last, is_last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  decimal_text_checker text_chk = new();
  bit tx_steady;
  bit rx_steady;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sink side: random stall before every word, none while rx_steady is set
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      text_chk.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // ends the run if nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_number(logic fixed_fmt, logic neg, logic [MAG_W-1:0] mag);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fixed_fmt;
    s_axis_tdata  <= {7'd0, mag, neg};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    text_chk.note_number(fixed_fmt, neg, mag);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (text_chk.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_fraction(logic [FRAC_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    text_chk.fraction = value;
  endtask

  function automatic logic [MAG_W-1:0] pick_magnitude();
    logic [MAG_W-1:0] p10;
    int               k;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 999);
      2: return $urandom >> $urandom_range(0, 31);
      3: begin
        p10 = 1;
        k   = $urandom_range(0, 9);
        repeat (k) p10 = p10 * 10;
        return p10 - $urandom_range(0, 1);
      end
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  initial begin
    logic [FRAC_W-1:0] settings[6];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset precision of three
    send_number(1'b0, 1'b0, 32'd0);
    send_number(1'b0, 1'b1, 32'd0);
    send_number(1'b1, 1'b0, 32'd0);
    send_number(1'b1, 1'b1, 32'd0);
    send_number(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_number(1'b0, 1'b1, 32'hFFFF_FFFF);
    send_number(1'b1, 1'b0, 32'hFFFF_FFFF);
    send_number(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_number(1'b1, 1'b0, 32'd5);
    send_number(1'b1, 1'b1, 32'd123);
    send_number(1'b1, 1'b0, 32'd1234);
    send_number(1'b1, 1'b0, 32'd1000);
    send_number(1'b0, 1'b0, 32'd1);
    send_number(1'b0, 1'b1, 32'd9);
    send_number(1'b0, 1'b0, 32'd10);
    send_number(1'b0, 1'b0, 32'hAAAA_AAAA);
    send_number(1'b0, 1'b0, 32'h5555_5555);

    // zero precision, above capacity, one below cap, cap, then random
    settings[0] = 4'd0;
    settings[1] = 4'd15;
    settings[2] = 4'd8;
    settings[3] = 4'd9;
    settings[4] = 4'($urandom_range(0, 15));
    settings[5] = 4'($urandom_range(0, 15));
    foreach (settings[ph]) begin
      write_fraction(settings[ph]);
      tx_steady = (ph == 2);
      rx_steady = (ph == 3);
      send_number(1'b1, 1'($urandom_range(0, 1)), 32'd0);
      send_number(1'b1, 1'($urandom_range(0, 1)), 32'hFFFF_FFFF);
      repeat (16) begin
        send_number(($urandom_range(0, 9) < 6), 1'($urandom_range(0, 1)), pick_magnitude());
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (text_chk.errors == 0 && text_chk.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/dtf_pkg.sv
sv/dtf_dabble.sv
sv/dtf_serial.sv
sv/decimal_text_formatter_top.sv
tb/sv/tb_top.sv
